@@ src/gvpe_pkg.sv @@
// Shared types, constants and GF(256) helpers for the Vandermonde parity encoder.
package gvpe_pkg;

  localparam int unsigned MAX_DATA   = 8;
  localparam int unsigned MAX_PARITY = 4;

  // Field polynomial x^8+x^4+x^3+x^2+1 and the carry-out bit it clears.
  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_CARRY = 9'h100;

  localparam logic [3:0] DATA_SHARDS_RST   = 4'd4;
  localparam logic [2:0] PARITY_SHARDS_RST = 3'd2;

  // Register index decoded from the APB address.
  localparam logic REG_DATA_SHARDS   = 1'b0;
  localparam logic REG_PARITY_SHARDS = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data_byte_0;
    byte_t data_byte_1;
    byte_t data_byte_2;
    byte_t data_byte_3;
    byte_t data_byte_4;
    byte_t data_byte_5;
    byte_t data_byte_6;
    byte_t data_byte_7;
  } in_req_t;

  typedef struct packed {
    byte_t parity_byte_0;
    byte_t parity_byte_1;
    byte_t parity_byte_2;
    byte_t parity_byte_3;
  } out_req_t;

  typedef byte_t [MAX_PARITY-1:0] coef_col_t;
  typedef coef_col_t [MAX_DATA-1:0] coef_mat_t;
  typedef byte_t [MAX_DATA-1:0][MAX_DATA-1:0] pow_row_t;
  typedef byte_t [15:0][MAX_DATA-1:0] pow_tbl_t;

  // Shift-and-add multiply with reduction after every shift.
  function automatic byte_t gf_mul(byte_t a, byte_t b);
    logic [8:0] x;
    byte_t      acc;
    acc = '0;
    x   = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if ((x & GF_CARRY) != 9'h000) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // Powers base^d for every 4-bit base, built at elaboration.
  function automatic pow_tbl_t gen_pow_tbl();
    pow_tbl_t t;
    byte_t    c;
    for (int b = 0; b < 16; b++) begin
      c = 8'h01;
      for (int d = 0; d < MAX_DATA; d++) begin
        t[b][d] = c;
        c = gf_mul(c, byte_t'(b));
      end
    end
    return t;
  endfunction

  localparam pow_tbl_t POW_TBL = gen_pow_tbl();

  // Coefficient matrix for the given register values; unused entries are zero.
  function automatic coef_mat_t coef_matrix(logic [3:0] data_shards, logic [2:0] parity_shards);
    coef_mat_t  m;
    logic [3:0] k;
    logic [2:0] np;
    logic [3:0] base;
    k  = (data_shards == 4'd0) ? 4'd1 :
         (data_shards > 4'(MAX_DATA)) ? 4'(MAX_DATA) : data_shards;
    np = (parity_shards == 3'd0) ? 3'd1 :
         (parity_shards > 3'(MAX_PARITY)) ? 3'(MAX_PARITY) : parity_shards;
    for (int d = 0; d < MAX_DATA; d++) begin
      for (int p = 0; p < MAX_PARITY; p++) begin
        base = k + 4'(p) + 4'd1;
        if ((4'(d) < k) && (3'(p) < np)) begin
          m[d][p] = POW_TBL[base][d];
        end else begin
          m[d][p] = 8'h00;
        end
      end
    end
    return m;
  endfunction

endpackage

@@ src/gf256_vandermonde_parity_encoder_core.sv @@
// Top level of the GF(256) Vandermonde parity encoder with APB configuration.
//
//   Channel   Direction   Handshake                 Payload
//   in        request in  in_valid_i / in_stall_o   in_data_i  (gvpe_pkg::in_req_t)
//   out       request out out_valid_o / out_stall_i out_data_o (gvpe_pkg::out_req_t)
//   config    APB slave   psel / penable / pready   paddr, pwdata, prdata
//
// The block takes one request per cycle while in_stall_o is low and passes
// each through an input register, the lane multiplier register and the
// merge (XOR) output register.
// Reset clears the pipeline valid bits and loads four data shards and two
// parity shards; no clearing pass is needed.
// A stall on the output holds the output register and backs up through the
// pipeline; a request is still taken while any stage ahead of it has room.
//
// Each of the eight data lanes multiplies its byte by its column of the
// coefficient matrix (one GF(256) multiplier per parity shard). The merge
// stage XORs the lane products per parity shard. The coefficient matrix is
// kept in registers and refreshed from the shard counts every cycle; unused
// data lanes and unused parity shards have zero coefficients, which makes
// ignored bytes drop out and unused parity bytes read as zero.
module gf256_vandermonde_parity_encoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gvpe_pkg::in_req_t  in_data_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gvpe_pkg::out_req_t out_data_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gvpe_pkg::*;

  localparam int unsigned NUM_STAGES = 3;

  // Configuration registers.
  logic [3:0] data_shards_d, data_shards_q;
  logic [2:0] parity_shards_d, parity_shards_q;
  logic       cfg_write;
  logic       reg_sel;

  // Pipeline control: stage 0 input register, stage 1 lane products,
  // stage 2 merged output.
  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic [NUM_STAGES-1:0] adv;
  logic                  in_accept;

  in_req_t   in_q;
  byte_t     lane_data [MAX_DATA];
  coef_mat_t coef;
  coef_mat_t prod;

  // ---------------------------------------------------------------------
  // APB register port. The register index is the address divided by four.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];

  always_comb begin
    data_shards_d   = data_shards_q;
    parity_shards_d = parity_shards_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_DATA_SHARDS:   data_shards_d   = pwdata[3:0];
        REG_PARITY_SHARDS: parity_shards_d = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DATA_SHARDS:   prdata = {28'd0, data_shards_q};
      REG_PARITY_SHARDS: prdata = {29'd0, parity_shards_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_shards_q   <= DATA_SHARDS_RST;
      parity_shards_q <= PARITY_SHARDS_RST;
    end else begin
      data_shards_q   <= data_shards_d;
      parity_shards_q <= parity_shards_d;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake. A stage moves when it is empty or the stage after
  // it moves; the last stage moves when the output is not stalled.
  // ---------------------------------------------------------------------
  assign adv[2]     = !valid_q[2] || !out_stall_i;
  assign adv[1]     = !valid_q[1] || adv[2];
  assign adv[0]     = !valid_q[0] || adv[1];
  assign in_stall_o = !adv[0];
  assign in_accept  = in_valid_i && adv[0];

  always_comb begin
    valid_d    = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    if (adv[1]) begin
      valid_d[1] = valid_q[0];
    end
    if (adv[2]) begin
      valid_d[2] = valid_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The input register lets a shard-count write settle into the coefficient
  // matrix before the first request after it reaches the multipliers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  assign lane_data[0] = in_q.data_byte_0;
  assign lane_data[1] = in_q.data_byte_1;
  assign lane_data[2] = in_q.data_byte_2;
  assign lane_data[3] = in_q.data_byte_3;
  assign lane_data[4] = in_q.data_byte_4;
  assign lane_data[5] = in_q.data_byte_5;
  assign lane_data[6] = in_q.data_byte_6;
  assign lane_data[7] = in_q.data_byte_7;

  gvpe_coef u_coef (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_shards_i   (data_shards_q),
    .parity_shards_i (parity_shards_q),
    .coef_o          (coef)
  );

  for (genvar d = 0; d < MAX_DATA; d++) begin : g_lane
    gvpe_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv[1] && valid_q[0]),
      .data_i (lane_data[d]),
      .coef_i (coef[d]),
      .prod_o (prod[d])
    );
  end

  gvpe_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (adv[2] && valid_q[1]),
    .prod_i   (prod),
    .parity_o (out_data_o)
  );

  assign out_valid_o = valid_q[2];

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // An accepted request always lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> valid_q[0])
    else $error("accepted request did not enter the input register");

  // The input side only stalls while every pipeline stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q[0] && valid_q[1] && valid_q[2])
    else $error("input stalled with room in the pipeline");

  // Shard 0 always feeds parity shard 0 with coefficient one.
  a_coef_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef[0][0] == 8'h01)
    else $error("leading coefficient is not one");

  // A stalled result in the output register moves nowhere and nothing drops.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && out_stall_i && valid_q[1] |=> valid_q[2] && valid_q[1])
    else $error("pipeline dropped a result while stalled");

endmodule

@@ src/gvpe_coef.sv @@
// Coefficient matrix register derived from the shard-count registers.
module gvpe_coef (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        data_shards_i,
  input  logic [2:0]        parity_shards_i,
  output gvpe_pkg::coef_mat_t coef_o
);
  import gvpe_pkg::*;

  coef_mat_t coef_d, coef_q;

  // The user must change the counts only while the pipeline is empty; this
  // is not enforced. The matrix follows the counts in the next cycle.
  assign coef_d = coef_matrix(data_shards_i, parity_shards_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= coef_matrix(DATA_SHARDS_RST, PARITY_SHARDS_RST);
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

@@ src/gvpe_lane.sv @@
// One data-shard lane: multiplies its byte by each parity coefficient.
module gvpe_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  gvpe_pkg::byte_t     data_i,
  input  gvpe_pkg::coef_col_t coef_i,
  output gvpe_pkg::coef_col_t prod_o
);
  import gvpe_pkg::*;

  coef_col_t prod_d, prod_q;

  always_comb begin
    for (int p = 0; p < MAX_PARITY; p++) begin
      prod_d[p] = gf_mul(coef_i[p], data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ src/gvpe_merge.sv @@
// Merge stage: XORs the lane products into the registered parity bytes.
module gvpe_merge (
  input  logic                clk_i,
  input  logic                en_i,
  input  gvpe_pkg::coef_mat_t prod_i,
  output gvpe_pkg::out_req_t  parity_o
);
  import gvpe_pkg::*;

  coef_col_t sum_d;
  out_req_t  parity_q;

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < MAX_DATA; d++) begin
      sum_d = sum_d ^ prod_i[d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      parity_q.parity_byte_0 <= sum_d[0];
      parity_q.parity_byte_1 <= sum_d[1];
      parity_q.parity_byte_2 <= sum_d[2];
      parity_q.parity_byte_3 <= sum_d[3];
    end
  end

  assign parity_o = parity_q;

endmodule

@@ sim/tb_gf256_vandermonde_parity_encoder_core.sv @@
// Self-checking testbench for the GF(256) Vandermonde parity encoder core.
`timescale 1ns / 1ps

module tb_gf256_vandermonde_parity_encoder_core;
  import gvpe_pkg::*;

  // The core passes each request through its input, lane product and merge registers.
  localparam int PIPE_LAT     = 3;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 100;

  // Byte addresses of the two shard-count registers (register i at 4*i).
  localparam logic [2:0] ADDR_DATA_SHARDS   = 3'd0;
  localparam logic [2:0] ADDR_PARITY_SHARDS = 3'd4;

  // One row of the directed table. When reprogram is set the core is drained
  // and both shard counts are written before the request goes in. Rows with
  // known set carry a hand-written answer; the rest use the predictor.
  typedef struct packed {
    logic        reprogram;
    logic [31:0] k_word;
    logic [31:0] np_word;
    in_req_t     req;
    logic        known;
    out_req_t    want;
  } dir_row_t;

  localparam int DIR_ROWS = 17;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Reset values: four data shards, two parity shards.
    '{1'b0, 32'd0, 32'd0, 64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'hFF00_0000_0000_0000, 1'b1, 32'hFFFF_0000},
    '{1'b0, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0000_0000},
    // Bytes only in the unused lanes must drop out entirely.
    '{1'b0, 32'd0, 32'd0, 64'h0000_0000_FFFF_FFFF, 1'b1, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF, 1'b0, 32'h0000_0000},
    // Zero counts act as one: parity 0 copies lane 0, the rest read zero.
    '{1'b1, 32'd0, 32'd0, 64'hAB12_3456_789A_BCDE, 1'b1, 32'hAB00_0000},
    // One data shard, four parity shards: every parity byte copies lane 0.
    '{1'b1, 32'd1, 32'd4, 64'h5AFF_FFFF_FFFF_FFFF, 1'b1, 32'h5A5A_5A5A},
    // Full width.
    '{1'b1, 32'd8, 32'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'h55AA_55AA_55AA_55AA, 1'b0, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'h0000_0000_0000_0001, 1'b0, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'h8040_2010_0804_0201, 1'b0, 32'h0000_0000},
    // Counts at the top of their register range saturate.
    '{1'b1, 32'd15, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0000_0000},
    '{1'b0, 32'd0, 32'd0, 64'h0000_0000_0000_0080, 1'b0, 32'h0000_0000},
    // Stray high bits in the write data are masked off (two and three).
    '{1'b1, 32'hFFFF_FFF2, 32'h0000_00FB, 64'hFFFF_0000_0000_0000, 1'b0, 32'h0},
    '{1'b0, 32'd0, 32'd0, 64'h1234_FFFF_FFFF_FFFF, 1'b0, 32'h0000_0000},
    // Just above the maximum.
    '{1'b1, 32'd9, 32'd5, 64'hD1E2_F3A4_B5C6_9788, 1'b0, 32'h0000_0000},
    '{1'b1, 32'd4, 32'd2, 64'h0102_0304_0506_0708, 1'b0, 32'h0000_0000}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_req_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_req_t    out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  gf256_vandermonde_parity_encoder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copies of the shard-count registers, at their register widths.
  logic [3:0] shadow_data_shards   = DATA_SHARDS_RST;
  logic [2:0] shadow_parity_shards = PARITY_SHARDS_RST;

  // Parity bytes still owed by the core, oldest first.
  out_req_t pending_parity[$];
  out_req_t parity_want;
  int       error_count   = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_left     = 0;
  bit       hold_arm      = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // GF(256) product, Horner style from the top bit of a; each step doubles
  // the running sum and folds x^8 back in through the field polynomial.
  function automatic byte_t gf_times(byte_t a, byte_t b);
    byte_t acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1D : 8'h00);
      if (a[i]) begin
        acc = acc ^ b;
      end
    end
    return acc;
  endfunction

  // Effective shard count: zero reads as one, anything above hi as hi.
  function automatic int unsigned shard_count(int unsigned v, int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  // Parity bytes for one position under the current shadow registers.
  function automatic out_req_t expected_parity(in_req_t req);
    byte_t       lane [MAX_DATA];
    byte_t       par  [MAX_PARITY];
    byte_t       base;
    byte_t       coef;
    int unsigned k;
    int unsigned np;
    out_req_t    res;
    lane[0] = req.data_byte_0;
    lane[1] = req.data_byte_1;
    lane[2] = req.data_byte_2;
    lane[3] = req.data_byte_3;
    lane[4] = req.data_byte_4;
    lane[5] = req.data_byte_5;
    lane[6] = req.data_byte_6;
    lane[7] = req.data_byte_7;
    k  = shard_count(shadow_data_shards, MAX_DATA);
    np = shard_count(shadow_parity_shards, MAX_PARITY);
    for (int p = 0; p < MAX_PARITY; p++) begin
      par[p] = 8'h00;
      if (p < np) begin
        // Row p of the Vandermonde matrix uses base k+p+1.
        base = byte_t'(k + p + 1);
        coef = 8'h01;
        for (int d = 0; d < k; d++) begin
          par[p] = par[p] ^ gf_times(coef, lane[d]);
          coef   = gf_times(coef, base);
        end
      end
    end
    res.parity_byte_0 = par[0];
    res.parity_byte_1 = par[1];
    res.parity_byte_2 = par[2];
    res.parity_byte_3 = par[3];
    return res;
  endfunction

  // Random shard bytes, with all-zero and all-one bytes mixed in often.
  function automatic in_req_t random_req();
    in_req_t r;
    int      pick;
    for (int d = 0; d < MAX_DATA; d++) begin
      pick = $urandom_range(9);
      r[(MAX_DATA-1-d)*8 +: 8] = (pick == 0) ? 8'h00 :
                                 (pick == 1) ? 8'hFF : byte_t'($urandom);
    end
    return r;
  endfunction

  // APB write: setup cycle, then access cycle held until pready. The shadow
  // register is updated at the same point, masked to its width.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2] == REG_DATA_SHARDS) begin
      shadow_data_shards = data[3:0];
    end else begin
      shadow_parity_shards = data[2:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering requests and wait until the core has returned everything,
  // plus its pipeline depth, so that a register write lands on an idle core.
  task automatic drain_core();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_parity.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic program_shards(input logic [31:0] k_word, input logic [31:0] np_word);
    drain_core();
    apb_write(ADDR_DATA_SHARDS, k_word);
    apb_write(ADDR_PARITY_SHARDS, np_word);
  endtask

  // Offer one request, after a random number of idle cycles, and hold it
  // until the core takes it. The expected parity is queued on acceptance.
  task automatic offer_request(input in_req_t req, input out_req_t want);
    bit taken;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    pending_parity.push_back(want);
  endtask

  // Output side stall. A hold request from the stimulus blocks the output
  // for a long stretch so that the pipeline fills and the input stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_arm) begin
      hold_arm    = 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every accepted result is checked byte by byte against the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_parity.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, out_data_o);
        error_count++;
      end else begin
        parity_want = pending_parity.pop_front();
        for (int p = 0; p < MAX_PARITY; p++) begin
          if (parity_want[(MAX_PARITY-1-p)*8 +: 8] !== out_data_o[(MAX_PARITY-1-p)*8 +: 8])
          begin
            $display("%0t: parity byte %0d expected %h actual %h", $time, p,
                     parity_want[(MAX_PARITY-1-p)*8 +: 8],
                     out_data_o[(MAX_PARITY-1-p)*8 +: 8]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    in_req_t     req;
    logic [31:0] k_word;
    logic [31:0] np_word;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, run with the sender idling more rarely than the receiver.
    send_idle_pct = 36;
    recv_idle_pct = 45;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].reprogram) begin
        program_shards(DIRECTED[i].k_word, DIRECTED[i].np_word);
      end
      offer_request(DIRECTED[i].req,
                    DIRECTED[i].known ? DIRECTED[i].want : expected_parity(DIRECTED[i].req));
    end

    // Random phases. The first six settings are the corners of the count
    // ranges; the rest are random, sometimes with junk in the upper bits.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin k_word = 32'd1;  np_word = 32'd1; end
        1: begin k_word = 32'd8;  np_word = 32'd4; end
        2: begin k_word = 32'd0;  np_word = 32'd0; end
        3: begin k_word = 32'd15; np_word = 32'd7; end
        4: begin k_word = 32'd1;  np_word = 32'd4; end
        5: begin k_word = 32'd8;  np_word = 32'd1; end
        default: begin
          k_word  = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(15));
          np_word = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
        end
      endcase
      program_shards(k_word, np_word);

      // Sender idles less than the receiver first, then the other way round,
      // then neither idles at all.
      if (ph < 5) begin
        send_idle_pct = 36;
        recv_idle_pct = 45;
      end else if (ph < 10) begin
        send_idle_pct = 45;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 10) begin
        hold_arm = 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        req = random_req();
        offer_request(req, expected_parity(req));
      end
    end

    drain_core();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
